// ----- rtl/mwt_pkg.sv -----
// Shared types, operation codes and the compare helper for the watchpoint table.
// No dependencies; used by mwt_cell and memory_watchpoint_table_core.
`default_nettype none
package mwt_pkg;

  localparam int MWT_ENTRIES   = 16;
  localparam int MWT_ADDR_BITS = 16;
  localparam int MWT_PORT_ADDR = 16;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_DEL   = 2'd1;
  localparam logic [1:0] FUNC_EVAL  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [2:0] MODE_EQ = 3'd0;
  localparam logic [2:0] MODE_NE = 3'd1;
  localparam logic [2:0] MODE_LT = 3'd2;
  localparam logic [2:0] MODE_LE = 3'd3;
  localparam logic [2:0] MODE_GT = 3'd4;
  localparam logic [2:0] MODE_GE = 3'd5;

  // Command token handed from cell to cell.
  typedef struct packed {
    logic       vld;
    logic [1:0] func;
    logic [7:0] data;
    logic [1:0] acc;
    logic [2:0] mode;
    logic [7:0] cval;
    logic       act;
    logic       found;
    logic       free_found;
    logic       hit;
  } mwt_tok_t;

  // Payload broadcast to the slot chosen by an add.
  typedef struct packed {
    logic [1:0] mask;
    logic [2:0] mode;
    logic [7:0] cval;
    logic       act;
  } mwt_wr_t;

  function automatic logic mwt_cmp(input logic [2:0] mode, input logic [7:0] data,
                                   input logic [7:0] ref_val);
    logic r;
    case (mode)
      MODE_EQ: r = (data == ref_val);
      MODE_NE: r = (data != ref_val);
      MODE_LT: r = (data <  ref_val);
      MODE_LE: r = (data <= ref_val);
      MODE_GT: r = (data >  ref_val);
      MODE_GE: r = (data >= ref_val);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mwt_cell.sv -----
// One watchpoint slot plus one stage of the command chain.
// Depends on mwt_pkg.
`default_nettype none
module mwt_cell #(
  parameter int AW    = mwt_pkg::MWT_ADDR_BITS,
  parameter int IDX_W = 4,
  parameter int SLOT  = 0
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire mwt_pkg::mwt_tok_t tok_in,
  input  wire  [AW-1:0]          addr_in,
  input  wire  [IDX_W-1:0]       midx_in,
  input  wire  [IDX_W-1:0]       fidx_in,
  output mwt_pkg::mwt_tok_t      tok_out,
  output logic [AW-1:0]          addr_out,
  output logic [IDX_W-1:0]       midx_out,
  output logic [IDX_W-1:0]       fidx_out,
  input  wire                    wr_en,
  input  wire  [IDX_W-1:0]       wr_idx,
  input  wire  [AW-1:0]          wr_addr,
  input  wire mwt_pkg::mwt_wr_t  wr_data
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT);

  logic              valid_r, valid_nxt;
  logic [AW-1:0]     addr_r;
  mwt_pkg::mwt_wr_t  ent_r;
  mwt_pkg::mwt_tok_t tok_r, tok_nxt;
  logic [AW-1:0]     taddr_r;
  logic [IDX_W-1:0]  midx_r, midx_nxt, fidx_r, fidx_nxt;
  logic              match;
  logic              wr_me;

  assign match = tok_in.vld && valid_r && (addr_r == addr_in);
  assign wr_me = wr_en && (wr_idx == MY_IDX);

  always_comb begin
    tok_nxt  = tok_in;
    midx_nxt = midx_in;
    fidx_nxt = fidx_in;
    if (match) begin
      tok_nxt.found = 1'b1;
      midx_nxt      = MY_IDX;
      if (tok_in.func == mwt_pkg::FUNC_EVAL) begin
        tok_nxt.hit = ent_r.act && (|(ent_r.mask & tok_in.acc)) &&
                      mwt_pkg::mwt_cmp(ent_r.mode, tok_in.data, ent_r.cval);
      end
    end
    // take the lowest free slot
    if (tok_in.vld && !tok_in.free_found && !valid_r) begin
      tok_nxt.free_found = 1'b1;
      fidx_nxt           = MY_IDX;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (tok_in.vld && tok_in.func == mwt_pkg::FUNC_CLEAR) begin
      valid_nxt = 1'b0;
    end else if (match && tok_in.func == mwt_pkg::FUNC_DEL) begin
      valid_nxt = 1'b0;
    end
    if (wr_me) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.func       <= tok_nxt.func;
    tok_r.data       <= tok_nxt.data;
    tok_r.acc        <= tok_nxt.acc;
    tok_r.mode       <= tok_nxt.mode;
    tok_r.cval       <= tok_nxt.cval;
    tok_r.act        <= tok_nxt.act;
    tok_r.found      <= tok_nxt.found;
    tok_r.free_found <= tok_nxt.free_found;
    tok_r.hit        <= tok_nxt.hit;
    taddr_r          <= addr_in;
    midx_r           <= midx_nxt;
    fidx_r           <= fidx_nxt;
    if (wr_me) begin
      addr_r <= wr_addr;
      ent_r  <= wr_data;
    end
  end

  assign tok_out  = tok_r;
  assign addr_out = taddr_r;
  assign midx_out = midx_r;
  assign fidx_out = fidx_r;

endmodule
`default_nettype wire

// ----- rtl/memory_watchpoint_table_core.sv -----
// Top level of the data watchpoint table: command chain of slot cells.
// Depends on mwt_pkg and mwt_cell.
// One command in flight at a time: start is accepted only while busy is low.
// The token walks the chain of ENTRIES cells one per cycle, then the tail writes
// back the chosen slot as the result beat is registered.
// Reset (synchronous, rst_n low) empties the table and drops any command in flight.
// The receiver cannot stall: each result beat shows for exactly one cycle.
`default_nettype none
module memory_watchpoint_table_core #(
  parameter int ENTRIES   = mwt_pkg::MWT_ENTRIES,
  parameter int ADDR_BITS = mwt_pkg::MWT_ADDR_BITS
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [1:0]                        in_func,
  input  wire  [mwt_pkg::MWT_PORT_ADDR-1:0] in_address,
  input  wire  [7:0]                        in_data_value,
  input  wire  [1:0]                        in_access_bits,
  input  wire  [2:0]                        in_compare_mode,
  input  wire  [7:0]                        in_compare_value,
  input  wire                               in_active_flag,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [3:0]                        out_hit_slot,
  output logic                              out_status
);

  // only the low bits of the port address take part
  localparam int AW    = (ADDR_BITS < mwt_pkg::MWT_PORT_ADDR) ? ADDR_BITS
                                                              : mwt_pkg::MWT_PORT_ADDR;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  mwt_pkg::mwt_tok_t tok   [0:ENTRIES];
  logic [AW-1:0]     taddr [0:ENTRIES];
  logic [IDX_W-1:0]  midx  [0:ENTRIES];
  logic [IDX_W-1:0]  fidx  [0:ENTRIES];
  logic [ENTRIES-1:0] tok_vld;

  logic             accept;
  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_hit_r, out_status_r;
  logic [3:0]       out_hit_slot_r;
  mwt_pkg::mwt_tok_t last;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  mwt_pkg::mwt_wr_t wr_data;

  assign accept = start && !busy_r;

  // Launch a fresh token into the head of the chain.
  always_comb begin
    tok[0].vld        = accept;
    tok[0].func       = in_func;
    tok[0].data       = in_data_value;
    tok[0].acc        = in_access_bits;
    tok[0].mode       = in_compare_mode;
    tok[0].cval       = in_compare_value;
    tok[0].act        = in_active_flag;
    tok[0].found      = 1'b0;
    tok[0].free_found = 1'b0;
    tok[0].hit        = 1'b0;
  end
  assign taddr[0] = in_address[AW-1:0];
  assign midx[0]  = '0;
  assign fidx[0]  = '0;

  // Tail of the chain: an add writes the matching slot, else the lowest free one.
  assign last    = tok[ENTRIES];
  assign wr_en   = last.vld && (last.func == mwt_pkg::FUNC_ADD) &&
                   (last.found || last.free_found);
  assign wr_idx  = last.found ? midx[ENTRIES] : fidx[ENTRIES];
  assign wr_data = '{mask: last.acc, mode: last.mode, cval: last.cval, act: last.act};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    mwt_cell #(
      .AW    (AW),
      .IDX_W (IDX_W),
      .SLOT  (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok[i]),
      .addr_in  (taddr[i]),
      .midx_in  (midx[i]),
      .fidx_in  (fidx[i]),
      .tok_out  (tok[i+1]),
      .addr_out (taddr[i+1]),
      .midx_out (midx[i+1]),
      .fidx_out (fidx[i+1]),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_addr  (taddr[ENTRIES]),
      .wr_data  (wr_data)
    );
    assign tok_vld[i] = tok[i+1].vld;
  end

  // Hold busy from accept until the token leaves the last cell.
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (last.vld) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= last.vld;
    end
  end

  // Register the result beat; refuse an add only when no match and no free slot.
  always_ff @(posedge clk) begin
    out_hit_r      <= last.func == mwt_pkg::FUNC_EVAL && last.found && last.hit;
    out_hit_slot_r <= (last.func == mwt_pkg::FUNC_EVAL && last.found && last.hit)
                      ? 4'(midx[ENTRIES]) : 4'd0;
    out_status_r   <= (last.func == mwt_pkg::FUNC_ADD) && !last.found &&
                      !last.free_found;
  end

  assign busy         = busy_r;
  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_hit_slot = out_hit_slot_r;
  assign out_status   = out_status_r;

  // At most one command walks the chain.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld)) else $error("more than one token in chain");

  // A token in the chain means the block is busy.
  a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (|tok_vld) |-> busy_r) else $error("token in chain while idle");

  // Accepting a command raises busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r) else $error("busy not raised after accept");

  // A result beat is never both a hit and a refused add.
  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_status)) else $error("hit and full together");

  // The result beat lands only after the chain has drained.
  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy_r) else $error("result beat while busy");

endmodule
`default_nettype wire

// ----- sim/memory_watchpoint_table_core_test.sv -----
// Self-checking bench for memory_watchpoint_table_core: scripted commands, then random traffic.
// Depends on mwt_pkg for operation and mode codes; carries its own model of the slot table.
module memory_watchpoint_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // operation and compare codes from the shared package
  localparam logic [1:0] FUNC_ADD   = mwt_pkg::FUNC_ADD;
  localparam logic [1:0] FUNC_DEL   = mwt_pkg::FUNC_DEL;
  localparam logic [1:0] FUNC_EVAL  = mwt_pkg::FUNC_EVAL;
  localparam logic [1:0] FUNC_CLEAR = mwt_pkg::FUNC_CLEAR;

  localparam logic [2:0] MODE_EQ = mwt_pkg::MODE_EQ;
  localparam logic [2:0] MODE_NE = mwt_pkg::MODE_NE;
  localparam logic [2:0] MODE_LT = mwt_pkg::MODE_LT;
  localparam logic [2:0] MODE_LE = mwt_pkg::MODE_LE;
  localparam logic [2:0] MODE_GT = mwt_pkg::MODE_GT;
  localparam logic [2:0] MODE_GE = mwt_pkg::MODE_GE;

  localparam int ENTRIES     = mwt_pkg::MWT_ENTRIES;
  localparam int AW          = mwt_pkg::MWT_PORT_ADDR;
  localparam int RANDOM_CMDS = 1500;
  localparam int POOL_SIZE   = 24;
  localparam int DRAIN_EVERY = 256;
  localparam int STALL_LIMIT = 500;
  // latency of one command through the cell chain plus write-back
  localparam int LATENCY     = ENTRIES + 1;

  // compare modes the block treats as never matching
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  localparam logic [1:0] ACC_NONE  = 2'b00;
  localparam logic [1:0] ACC_READ  = 2'b01;
  localparam logic [1:0] ACC_WRITE = 2'b10;
  localparam logic [1:0] ACC_RW    = 2'b11;

  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FULL = 1'b1;

  localparam logic FIXED = 1'b1;
  localparam logic MODEL = 1'b0;

  typedef struct packed {
    logic [1:0]    func;
    logic [AW-1:0] address;
    logic [7:0]    data;
    logic [1:0]    acc;
    logic [2:0]    mode;
    logic [7:0]    cval;
    logic          act;
  } watch_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
    logic       status;
  } watch_res_t;

  typedef struct packed {
    logic [AW-1:0] address;
    logic [1:0]    mask;
    logic [2:0]    mode;
    logic [7:0]    cval;
    logic          act;
  } watch_entry_t;

  // One scripted row: the command, how many times to issue it (address steps by one
  // each time), and whether the expected beat is written out here or taken from the model.
  typedef struct packed {
    watch_cmd_t cmd;
    logic [3:0] reps;
    logic       fixed_exp;
    watch_res_t res;
  } script_row_t;

  localparam watch_res_t RES_DONE = '{1'b0, 4'd0, ST_DONE};
  localparam watch_res_t RES_FULL = '{1'b0, 4'd0, ST_FULL};

  localparam int SCRIPT_LEN = 33;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // empty table: nothing can hit
    '{'{FUNC_EVAL,  16'h0000, 8'h00, ACC_RW,    MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    '{'{FUNC_ADD,   16'h0000, 8'h00, ACC_RW,    MODE_EQ,    8'h00, 1'b1}, 4'd1, FIXED, RES_DONE},
    '{'{FUNC_EVAL,  16'h0000, 8'h00, ACC_READ,  MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED,
      '{1'b1, 4'd0, ST_DONE}},
    '{'{FUNC_ADD,   16'hFFFF, 8'h00, ACC_WRITE, MODE_GE,    8'hFF, 1'b1}, 4'd1, FIXED, RES_DONE},
    '{'{FUNC_EVAL,  16'hFFFF, 8'hFF, ACC_WRITE, MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED,
      '{1'b1, 4'd1, ST_DONE}},
    // access kind outside the stored mask
    '{'{FUNC_EVAL,  16'hFFFF, 8'hFF, ACC_READ,  MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    // no access bits at all
    '{'{FUNC_EVAL,  16'h0000, 8'h00, ACC_NONE,  MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    // overwrite an existing address in place
    '{'{FUNC_ADD,   16'h0000, 8'h00, ACC_READ,  MODE_NE,    8'h80, 1'b1}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_EVAL,  16'h0000, 8'h80, ACC_READ,  MODE_EQ,    8'h00, 1'b0}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_EVAL,  16'h0000, 8'h7F, ACC_RW,    MODE_EQ,    8'h00, 1'b0}, 4'd1, MODEL, RES_DONE},
    // reserved compare modes never hit
    '{'{FUNC_ADD,   16'h1234, 8'h00, ACC_RW,    MODE_RSVD6, 8'h00, 1'b1}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_EVAL,  16'h1234, 8'h00, ACC_RW,    MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    '{'{FUNC_ADD,   16'h1234, 8'h00, ACC_RW,    MODE_RSVD7, 8'h00, 1'b1}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_EVAL,  16'h1234, 8'h01, ACC_RW,    MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    // stored but disabled entry
    '{'{FUNC_ADD,   16'h2000, 8'h00, ACC_RW,    MODE_LT,    8'h10, 1'b0}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_EVAL,  16'h2000, 8'h00, ACC_RW,    MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    '{'{FUNC_ADD,   16'h2000, 8'h00, ACC_RW,    MODE_LT,    8'h10, 1'b1}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_EVAL,  16'h2000, 8'h0F, ACC_WRITE, MODE_EQ,    8'h00, 1'b0}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_ADD,   16'h3000, 8'h00, ACC_RW,    MODE_LE,    8'h10, 1'b1}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_EVAL,  16'h3000, 8'h10, ACC_READ,  MODE_EQ,    8'h00, 1'b0}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_ADD,   16'h3001, 8'h00, ACC_RW,    MODE_GT,    8'h10, 1'b1}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_EVAL,  16'h3001, 8'h10, ACC_READ,  MODE_EQ,    8'h00, 1'b0}, 4'd1, MODEL, RES_DONE},
    // delete of an address that is not there is ignored
    '{'{FUNC_DEL,   16'h5555, 8'h00, ACC_NONE,  MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    '{'{FUNC_DEL,   16'h0000, 8'h00, ACC_NONE,  MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    '{'{FUNC_EVAL,  16'h0000, 8'h7F, ACC_RW,    MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    // fill the table: the freed slot first, then the free slots above it in ascending order
    '{'{FUNC_ADD,   16'h4000, 8'h00, ACC_RW,    MODE_GT,    8'h00, 1'b1}, 4'd11, MODEL, RES_DONE},
    '{'{FUNC_ADD,   16'h400B, 8'h00, ACC_RW,    MODE_GT,    8'h00, 1'b1}, 4'd1, FIXED, RES_FULL},
    // a full table still takes a replacement of an address it holds
    '{'{FUNC_ADD,   16'hFFFF, 8'h00, ACC_RW,    MODE_EQ,    8'h55, 1'b1}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_EVAL,  16'h400A, 8'h01, ACC_RW,    MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED,
      '{1'b1, 4'd15, ST_DONE}},
    '{'{FUNC_CLEAR, 16'h0000, 8'h00, ACC_NONE,  MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    '{'{FUNC_EVAL,  16'h400A, 8'h01, ACC_RW,    MODE_EQ,    8'h00, 1'b0}, 4'd1, FIXED, RES_DONE},
    '{'{FUNC_ADD,   16'h400A, 8'h00, ACC_RW,    MODE_GT,    8'h00, 1'b1}, 4'd1, MODEL, RES_DONE},
    '{'{FUNC_EVAL,  16'h400A, 8'h01, ACC_RW,    MODE_EQ,    8'h00, 1'b0}, 4'd1, MODEL, RES_DONE}
  };

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [1:0]      in_func = FUNC_EVAL;
  logic [AW-1:0]   in_address = '0;
  logic [7:0]      in_data_value = '0;
  logic [1:0]      in_access_bits = ACC_NONE;
  logic [2:0]      in_compare_mode = MODE_EQ;
  logic [7:0]      in_compare_value = '0;
  logic            in_active_flag = 1'b0;
  logic            out_valid;
  logic            out_hit;
  logic [3:0]      out_hit_slot;
  logic            out_status;

  memory_watchpoint_table_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_address       (in_address),
    .in_data_value    (in_data_value),
    .in_access_bits   (in_access_bits),
    .in_compare_mode  (in_compare_mode),
    .in_compare_value (in_compare_value),
    .in_active_flag   (in_active_flag),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_hit_slot     (out_hit_slot),
    .out_status       (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the slot table, advanced once per accepted command.
  logic         shadow_valid [ENTRIES];
  watch_entry_t shadow_slot  [ENTRIES];

  // Beats the block still owes, oldest first.
  watch_res_t   owed_beats [$];

  logic [AW-1:0] addr_pool [POOL_SIZE];

  int errors = 0;
  int cmds_sent = 0;
  int hits_seen = 0;
  int fulls_seen = 0;
  int clears_sent = 0;
  int quiet_stretch = 0;

  function automatic int find_slot(input logic [AW-1:0] address);
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_valid[i] && shadow_slot[i].address == address) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and return the beat it must produce.
  function automatic watch_res_t apply_watch_cmd(input watch_cmd_t c);
    watch_res_t   r;
    watch_entry_t e;
    int           idx;
    logic         pass;
    r = RES_DONE;
    idx = find_slot(c.address);
    case (c.func)
      FUNC_ADD: begin
        // take the lowest free slot when the address is new
        if (idx < 0) begin
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!shadow_valid[i]) idx = i;
          end
        end
        if (idx < 0) begin
          r.status = ST_FULL;
        end else begin
          shadow_valid[idx] = 1'b1;
          shadow_slot[idx]  = '{c.address, c.acc, c.mode, c.cval, c.act};
        end
      end
      FUNC_DEL: begin
        if (idx >= 0) shadow_valid[idx] = 1'b0;
      end
      FUNC_EVAL: begin
        if (idx >= 0) begin
          e = shadow_slot[idx];
          case (e.mode)
            MODE_EQ: pass = (c.data == e.cval);
            MODE_NE: pass = (c.data != e.cval);
            MODE_LT: pass = (c.data <  e.cval);
            MODE_LE: pass = (c.data <= e.cval);
            MODE_GT: pass = (c.data >  e.cval);
            MODE_GE: pass = (c.data >= e.cval);
            default: pass = 1'b0;
          endcase
          if (e.act && (e.mask & c.acc) != 2'b00 && pass) begin
            r.hit  = 1'b1;
            r.slot = 4'(idx);
          end
        end
      end
      FUNC_CLEAR: begin
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic void refill_pool();
    foreach (addr_pool[i]) addr_pool[i] = AW'($urandom_range(0, (1 << AW) - 1));
  endfunction

  // Mostly well-formed traffic on a small address pool so that adds collide, the table
  // fills up and evaluates land on stored entries; a few beats are pure noise.
  function automatic watch_cmd_t next_random_cmd();
    watch_cmd_t c;
    int         pick;
    int         idx;
    pick = $urandom_range(0, 99);
    c.func    = FUNC_EVAL;
    c.address = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    c.data    = 8'($urandom_range(0, 255));
    c.acc     = 2'($urandom_range(0, 3));
    c.mode    = 3'($urandom_range(0, 7));
    c.cval    = 8'($urandom_range(0, 255));
    c.act     = 1'($urandom_range(0, 1));
    if (pick < 5) begin
      c.func    = 2'($urandom_range(0, 3));
      c.address = AW'($urandom_range(0, (1 << AW) - 1));
    end else if (pick < 40) begin
      c.func = FUNC_ADD;
      c.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
      c.act  = ($urandom_range(0, 5) != 0);
    end else if (pick < 52) begin
      c.func = FUNC_DEL;
      if ($urandom_range(0, 3) == 0) c.address = AW'($urandom_range(0, (1 << AW) - 1));
    end else if (pick < 54) begin
      c.func = FUNC_CLEAR;
      refill_pool();
    end else begin
      c.acc = ($urandom_range(0, 7) == 0) ? ACC_NONE : 2'($urandom_range(1, 3));
      idx = find_slot(c.address);
      // land on or next to the stored threshold half of the time
      if (idx >= 0 && $urandom_range(0, 1) == 1)
        c.data = 8'(int'(shadow_slot[idx].cval) + $urandom_range(0, 2) - 1);
    end
    return c;
  endfunction

  // Issue one command beat: idle for a random gap (or until the block has drained),
  // then hold start until the beat is taken, and record what it must return.
  task automatic issue_cmd(input watch_cmd_t c, input bit drain_first,
                           input bit use_fixed, input watch_res_t fixed_res);
    int         gap;
    watch_res_t predicted;
    if (quiet_stretch > 0) begin
      gap = 0;
      quiet_stretch--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 24) == 0) quiet_stretch = $urandom_range(8, 40);
    end
    if (drain_first && gap == 0) gap = 1;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain_first && owed_beats.size() != 0) @(posedge clk);
    end
    in_func          <= c.func;
    in_address       <= c.address;
    in_data_value    <= c.data;
    in_access_bits   <= c.acc;
    in_compare_mode  <= c.mode;
    in_compare_value <= c.cval;
    in_active_flag   <= c.act;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = apply_watch_cmd(c);
    owed_beats.insert(owed_beats.size(), use_fixed ? fixed_res : predicted);
    cmds_sent++;
    if (predicted.hit) hits_seen++;
    if (predicted.status == ST_FULL) fulls_seen++;
    if (c.func == FUNC_CLEAR) clears_sent++;
  endtask

  // Result side: every strobed beat must match the oldest owed beat.
  always @(posedge clk) begin
    watch_res_t want;
    if (rst_n && out_valid) begin
      if (owed_beats.size() == 0) begin
        $error("result beat with nothing outstanding: hit=%0b slot=%0d status=%0b",
               out_hit, out_hit_slot, out_status);
        errors++;
      end else begin
        want = owed_beats.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, out_hit);
          errors++;
        end
        if (out_hit_slot !== want.slot) begin
          $error("hit_slot: expected %0d, got %0d", want.slot, out_hit_slot);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, out_status);
          errors++;
        end
      end
    end
  end

  // End the run if neither side moves a beat for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    watch_cmd_t c;
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    refill_pool();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (SCRIPT[r]) begin
      c = SCRIPT[r].cmd;
      for (int k = 0; k < SCRIPT[r].reps; k++) begin
        issue_cmd(c, 1'b0, SCRIPT[r].fixed_exp, SCRIPT[r].res);
        c.address = c.address + 1'b1;
      end
    end

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      c = next_random_cmd();
      issue_cmd(c, (n % DRAIN_EVERY) == 0, 1'b0, RES_DONE);
    end

    start <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    // let any stray beat still in the chain show up
    repeat (2 * LATENCY) @(posedge clk);

    $display("Ran %0d commands (%0d random) across add, delete, evaluate and clear.",
             cmds_sent, RANDOM_CMDS);
    $display("Saw %0d watchpoint hits, %0d refused adds on a full table, %0d clears.",
             hits_seen, fulls_seen, clears_sent);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mwt_pkg.sv
rtl/mwt_cell.sv
rtl/memory_watchpoint_table_core.sv
sim/memory_watchpoint_table_core_test.sv
